// File: src/ps2mct_pkg.sv
// Package for the PS/2 mouse cursor tracker.
// Holds the widths, the byte-zero bit positions and the register indexes.
// No dependencies.
package ps2mct_pkg;

  localparam int COORD_BITS     = 12;
  localparam int SENS_FRAC_BITS = 4;
  localparam int SENS_BITS      = 8;
  localparam int BYTE_BITS      = 8;
  localparam int DELTA_BITS     = 9;
  localparam int MOVE_BITS      = COORD_BITS + 1;
  localparam int CFG_DATA_BITS  = (COORD_BITS > SENS_BITS) ? COORD_BITS : SENS_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // negated delta (one bit more) times zero-extended sensitivity
  localparam int PROD_BITS = (DELTA_BITS + 1) + (SENS_BITS + 1);
  localparam int STEP_BITS = PROD_BITS - SENS_FRAC_BITS;
  localparam int SUM_BITS  = ((STEP_BITS > COORD_BITS + 1) ? STEP_BITS : COORD_BITS + 1) + 1;

  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;
  localparam int BUTTON_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_H_RES       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_V_RES       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SENSITIVITY = 2'd2;

  localparam logic [COORD_BITS-1:0] H_RES_RESET = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] V_RES_RESET = COORD_BITS'(768);
  localparam logic [SENS_BITS-1:0]  SENS_RESET  = SENS_BITS'(16);

  typedef enum logic [1:0] {
    IDX_FIRST  = 2'd0,
    IDX_SECOND = 2'd1,
    IDX_THIRD  = 2'd2
  } byte_index_t;

endpackage

// File: src/ps2mct_byte_if.sv
// Valid/ready channel carrying one mouse byte per transfer.
// Depends on ps2mct_pkg.
interface ps2mct_byte_if;
  import ps2mct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: src/ps2mct_result_if.sv
// Valid/ready channel carrying one decoded packet result per transfer.
// Depends on ps2mct_pkg.
interface ps2mct_result_if;
  import ps2mct_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [COORD_BITS-1:0]       cursor_x;
  logic [COORD_BITS-1:0]       cursor_y;
  logic                        left_down;
  logic                        right_down;
  logic                        middle_down;
  logic                        left_released;
  logic                        right_released;
  logic                        middle_released;
  logic signed [MOVE_BITS-1:0] moved_x;
  logic signed [MOVE_BITS-1:0] moved_y;

  modport source (
    output valid, input ready,
    output cursor_x, output cursor_y,
    output left_down, output right_down, output middle_down,
    output left_released, output right_released, output middle_released,
    output moved_x, output moved_y
  );
  modport sink (
    input valid, output ready,
    input cursor_x, input cursor_y,
    input left_down, input right_down, input middle_down,
    input left_released, input right_released, input middle_released,
    input moved_x, input moved_y
  );
endinterface

// File: src/ps2_mouse_cursor_tracker_unit.sv
// PS/2 mouse cursor tracker: packet sync, delta scaling, clamped cursor update.
// Depends on ps2mct_pkg, ps2mct_byte_if and ps2mct_result_if.
//
//   channel     dir  transfer carries
//   byte_ch     in   data_byte, one mouse byte
//   res_ch      out  cursor x/y, button levels and releases, moved x/y
//   cfg_*       in   h_res, v_res, sensitivity writes
//
// Each byte is taken into an input register, then combinational logic (one
// 10x9 multiply per axis, an add and a clamp compare) updates the tracker
// state and, on the third byte, loads the result register.
// Sustained rate is one byte per cycle unless a result stalls; res_ch.valid
// is set from the result register when the third byte leaves the input register.
// Synchronous active-high reset; a stalled result only holds back a third byte.
module ps2_mouse_cursor_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ps2mct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ps2mct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  ps2mct_byte_if.sink                          byte_ch,
  ps2mct_result_if.source                      res_ch
);
  import ps2mct_pkg::*;

  function automatic logic [COORD_BITS-1:0] axis_update(
    input logic signed [DELTA_BITS:0] d,
    input logic [SENS_BITS-1:0]       s,
    input logic [COORD_BITS-1:0]      pos,
    input logic [COORD_BITS-1:0]      res
  );
    logic signed [PROD_BITS-1:0] prod;
    logic signed [STEP_BITS-1:0] step;
    logic signed [SUM_BITS-1:0]  np;
    logic signed [SUM_BITS-1:0]  res_s;
    logic [COORD_BITS-1:0]       top;
    prod  = PROD_BITS'(d) * PROD_BITS'($signed({1'b0, s}));
    step  = $signed(prod[PROD_BITS-1:SENS_FRAC_BITS]);
    np    = SUM_BITS'($signed({1'b0, pos})) + SUM_BITS'(step);
    res_s = $signed(SUM_BITS'(res));
    top   = (res == '0) ? '0 : res - COORD_BITS'(1);
    if (np < 0)
      return '0;
    else if (np >= res_s)
      return top;
    else
      return np[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0]  h_res;
  logic [COORD_BITS-1:0]  v_res;
  logic [SENS_BITS-1:0]   sensitivity;

  logic                   in_valid;
  logic [BYTE_BITS-1:0]   in_byte;

  byte_index_t            byte_index;
  byte_index_t            byte_index_next;
  logic [BYTE_BITS-1:0]   held0;
  logic [BYTE_BITS-1:0]   held1;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic [BUTTON_BITS-1:0] prev_buttons;

  logic                   out_valid;

  logic                   emit;
  logic                   advance;
  logic signed [DELTA_BITS:0] dx;
  logic signed [DELTA_BITS:0] neg_dy;
  logic [BUTTON_BITS-1:0] buttons;
  logic [BUTTON_BITS-1:0] released;
  logic [COORD_BITS-1:0]  nx;
  logic [COORD_BITS-1:0]  ny;

  assign emit    = (byte_index != IDX_FIRST) && (byte_index != IDX_SECOND);
  assign advance = in_valid && (!emit || !out_valid || res_ch.ready);
  assign byte_ch.ready = !in_valid || advance;
  assign res_ch.valid  = out_valid;

  always_comb begin
    dx      = (DELTA_BITS+1)'($signed({held0[XSIGN_BIT], held1}));
    neg_dy  = -(DELTA_BITS+1)'($signed({held0[YSIGN_BIT], in_byte}));
    buttons = held0[BUTTON_BITS-1:0];
    released = prev_buttons & ~buttons;
    nx = (dx == '0) ? pos_x : axis_update(dx, sensitivity, pos_x, h_res);
    ny = (neg_dy == '0) ? pos_y : axis_update(neg_dy, sensitivity, pos_y, v_res);
  end

  always_comb begin
    byte_index_next = byte_index;
    case (byte_index)
      IDX_FIRST:  if (in_byte[SYNC_BIT]) byte_index_next = IDX_SECOND;
      IDX_SECOND: byte_index_next = IDX_THIRD;
      default:    byte_index_next = IDX_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_res       <= H_RES_RESET;
      v_res       <= V_RES_RESET;
      sensitivity <= SENS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_H_RES:       h_res       <= cfg_data[COORD_BITS-1:0];
        CFG_V_RES:       v_res       <= cfg_data[COORD_BITS-1:0];
        CFG_SENSITIVITY: sensitivity <= cfg_data[SENS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      in_valid <= byte_ch.valid;
    end
    if (byte_ch.ready && byte_ch.valid) begin
      in_byte <= byte_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_FIRST;
      pos_x        <= '0;
      pos_y        <= '0;
      prev_buttons <= '0;
    end else if (advance) begin
      byte_index <= byte_index_next;
      if (emit) begin
        pos_x        <= nx;
        pos_y        <= ny;
        prev_buttons <= buttons;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_index == IDX_FIRST) held0 <= in_byte;
    if (advance && byte_index == IDX_SECOND) held1 <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      res_ch.cursor_x        <= nx;
      res_ch.cursor_y        <= ny;
      res_ch.left_down       <= buttons[0];
      res_ch.right_down      <= buttons[1];
      res_ch.middle_down     <= buttons[2];
      res_ch.left_released   <= released[0];
      res_ch.right_released  <= released[1];
      res_ch.middle_released <= released[2];
      res_ch.moved_x         <= $signed(MOVE_BITS'(nx) - MOVE_BITS'(pos_x));
      res_ch.moved_y         <= $signed(MOVE_BITS'(ny) - MOVE_BITS'(pos_y));
    end
  end

endmodule
